/* rtl/anls_pkg.sv */
// Shared types and constants for the Annex B NAL length scanner.
`default_nettype none

package anls_pkg;

    localparam int unsigned OUT_LEN_W = 16;
    localparam int unsigned TYPE_W    = 5;

    localparam logic [TYPE_W-1:0] NAL_TYPE_SPS     = 5'd7;
    localparam logic [TYPE_W-1:0] NAL_TYPE_PPS     = 5'd8;
    localparam logic [TYPE_W-1:0] NAL_TYPE_DEFAULT = 5'd1;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
    localparam logic [1:0] ZERO_RUN_CODE = 2'd2;

    typedef logic [TYPE_W-1:0]    nal_type_t;
    typedef logic [OUT_LEN_W-1:0] out_len_t;

endpackage

`default_nettype wire

/* rtl/anls_byte_if.sv */
// Byte stream channel: one buffer byte per transaction.
`default_nettype none

interface anls_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);

endinterface

`default_nettype wire

/* rtl/anls_result_if.sv */
// Result channel: SPS/PPS lengths and final NAL type, one transaction per buffer.
`default_nettype none

interface anls_result_if;

    logic                valid;
    logic                ready;
    anls_pkg::out_len_t  sps_bytes;
    logic                sps_found;
    anls_pkg::out_len_t  pps_bytes;
    logic                pps_found;
    anls_pkg::nal_type_t final_nal_type;

    modport source (output valid, output sps_bytes, output sps_found, output pps_bytes,
                    output pps_found, output final_nal_type, input ready);
    modport sink   (input valid, input sps_bytes, input sps_found, input pps_bytes,
                    input pps_found, input final_nal_type, output ready);

endinterface

`default_nettype wire

/* rtl/annexb_nal_length_scanner_core.sv */
// Top level: Annex B start code scanner that measures the last SPS and PPS NAL lengths.
//
// Takes one byte per cycle and updates its scan state in the same cycle. One
// result transaction leaves per buffer, in the cycle after the byte marked
// end_of_buffer is taken, through a single output register; the byte input
// stalls only while that register is full and not being drained. NAL lengths
// include their start code and saturate at 2^LEN_BITS-1; the result carries the
// low 16 bits. A start code whose 01 byte is the final byte is treated as data.
`default_nettype none

module annexb_nal_length_scanner_core #(
    parameter int unsigned LEN_BITS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    anls_byte_if.sink         stream,
    anls_result_if.source     result
);

    localparam logic [LEN_BITS:0] LEN_MAX = {1'b0, {LEN_BITS{1'b1}}};

    typedef logic [LEN_BITS-1:0] len_t;

    logic [1:0]          zero_run_reg,       zero_run_next;
    logic                inside_nal_reg,     inside_nal_next;
    logic                header_pending_reg, header_pending_next;
    anls_pkg::nal_type_t current_type_reg,   current_type_next;
    len_t                current_count_reg,  current_count_next;
    len_t                sps_len_reg,        sps_len_next;
    len_t                pps_len_reg,        pps_len_next;
    logic [1:0]          seen_flags_reg,     seen_flags_next;

    logic                out_valid_reg,      out_valid_next;
    anls_pkg::out_len_t  sps_bytes_reg,      sps_bytes_next;
    logic                sps_found_reg,      sps_found_next;
    anls_pkg::out_len_t  pps_bytes_reg,      pps_bytes_next;
    logic                pps_found_reg,      pps_found_next;
    anls_pkg::nal_type_t final_type_reg,     final_type_next;

    logic                fire;
    logic                last;
    logic                start_code;
    logic                close_en;
    anls_pkg::nal_type_t close_type;
    len_t                close_len;
    logic [LEN_BITS+15:0] sps_ext;
    logic [LEN_BITS+15:0] pps_ext;

    function automatic len_t sat_add(input len_t a, input logic [2:0] inc);
        logic [LEN_BITS:0] s;
        begin
            s = {1'b0, a} + {{(LEN_BITS-2){1'b0}}, inc};
            sat_add = (s > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : s[LEN_BITS-1:0];
        end
    endfunction

    assign stream.ready = !out_valid_reg || result.ready;
    assign fire         = stream.valid && stream.ready;
    assign last         = stream.end_of_buffer;
    assign start_code   = !last && (stream.data_byte == anls_pkg::BYTE_ONE)
                          && (zero_run_reg >= anls_pkg::ZERO_RUN_CODE);

    always_comb
    begin
        zero_run_next       = zero_run_reg;
        inside_nal_next     = inside_nal_reg;
        header_pending_next = header_pending_reg;
        current_type_next   = current_type_reg;
        current_count_next  = current_count_reg;
        sps_len_next        = sps_len_reg;
        pps_len_next        = pps_len_reg;
        seen_flags_next     = seen_flags_reg;
        close_en            = 1'b0;
        close_type          = current_type_reg;
        close_len           = current_count_reg;
        sps_bytes_next      = sps_bytes_reg;
        sps_found_next      = sps_found_reg;
        pps_bytes_next      = pps_bytes_reg;
        pps_found_next      = pps_found_reg;
        final_type_next     = final_type_reg;
        sps_ext             = '0;
        pps_ext             = '0;

        if (fire)
        begin
            if (start_code)
            begin
                close_en            = inside_nal_reg;
                inside_nal_next     = 1'b1;
                header_pending_next = 1'b1;
                current_count_next  = sat_add('0, {1'b0, zero_run_reg} + 3'd1);
                zero_run_next       = '0;
            end
            else
            begin
                if (header_pending_reg)
                begin
                    current_type_next   = stream.data_byte[anls_pkg::TYPE_W-1:0];
                    header_pending_next = 1'b0;
                end
                if (stream.data_byte == anls_pkg::BYTE_ZERO)
                begin
                    if (zero_run_reg == anls_pkg::ZERO_RUN_MAX)
                    begin
                        if (inside_nal_reg)
                        begin
                            current_count_next = sat_add(current_count_reg, 3'd1);
                        end
                    end
                    else
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                end
                else
                begin
                    if (inside_nal_reg)
                    begin
                        current_count_next = sat_add(current_count_reg,
                                                     {1'b0, zero_run_reg} + 3'd1);
                    end
                    zero_run_next = '0;
                end
                if (last)
                begin
                    close_en   = inside_nal_reg;
                    close_type = current_type_next;
                    close_len  = sat_add(current_count_next, {1'b0, zero_run_next});
                end
            end

            if (close_en)
            begin
                if (close_type == anls_pkg::NAL_TYPE_SPS)
                begin
                    sps_len_next       = close_len;
                    seen_flags_next[0] = 1'b1;
                end
                else if (close_type == anls_pkg::NAL_TYPE_PPS)
                begin
                    pps_len_next       = close_len;
                    seen_flags_next[1] = 1'b1;
                end
            end

            if (last)
            begin
                sps_ext         = {16'b0, sps_len_next};
                pps_ext         = {16'b0, pps_len_next};
                sps_found_next  = seen_flags_next[0];
                pps_found_next  = seen_flags_next[1];
                sps_bytes_next  = seen_flags_next[0] ? sps_ext[15:0] : '0;
                pps_bytes_next  = seen_flags_next[1] ? pps_ext[15:0] : '0;
                final_type_next = inside_nal_next ? current_type_next
                                                  : anls_pkg::NAL_TYPE_DEFAULT;

                zero_run_next       = '0;
                inside_nal_next     = 1'b0;
                header_pending_next = 1'b0;
                current_type_next   = anls_pkg::NAL_TYPE_DEFAULT;
                current_count_next  = '0;
                sps_len_next        = '0;
                pps_len_next        = '0;
                seen_flags_next     = '0;
            end
        end

        if (fire && last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg       <= '0;
            inside_nal_reg     <= 1'b0;
            header_pending_reg <= 1'b0;
            current_type_reg   <= anls_pkg::NAL_TYPE_DEFAULT;
            current_count_reg  <= '0;
            sps_len_reg        <= '0;
            pps_len_reg        <= '0;
            seen_flags_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            zero_run_reg       <= zero_run_next;
            inside_nal_reg     <= inside_nal_next;
            header_pending_reg <= header_pending_next;
            current_type_reg   <= current_type_next;
            current_count_reg  <= current_count_next;
            sps_len_reg        <= sps_len_next;
            pps_len_reg        <= pps_len_next;
            seen_flags_reg     <= seen_flags_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sps_bytes_reg  <= sps_bytes_next;
        sps_found_reg  <= sps_found_next;
        pps_bytes_reg  <= pps_bytes_next;
        pps_found_reg  <= pps_found_next;
        final_type_reg <= final_type_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.sps_bytes      = sps_bytes_reg;
    assign result.sps_found      = sps_found_reg;
    assign result.pps_bytes      = pps_bytes_reg;
    assign result.pps_found      = pps_found_reg;
    assign result.final_nal_type = final_type_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> out_valid_reg)
        else $error("final byte did not produce a result transaction");

    a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> (zero_run_reg == 2'd0) && !inside_nal_reg && !header_pending_reg
                         && (seen_flags_reg == 2'd0))
        else $error("scan state not cleared after final byte");

    a_header_in_nal: assert property (@(posedge clk) disable iff (!rst_n)
        header_pending_reg |-> inside_nal_reg)
        else $error("header pending outside a NAL");

    a_sps_zero_unseen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !sps_found_reg |-> (sps_bytes_reg == '0))
        else $error("SPS length nonzero without SPS seen");

    a_pps_zero_unseen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pps_found_reg |-> (pps_bytes_reg == '0))
        else $error("PPS length nonzero without PPS seen");

endmodule

`default_nettype wire
